FILE: design/bsc_pkg.sv
// Shared constants and register codes for the barometric compensation core.
`timescale 1ns / 1ps

package bsc_pkg;

    localparam int RAW_W         = 24;
    localparam int TEMP_W        = 24;
    localparam int PRESS_W       = 32;
    localparam int DIGIT_W       = 16;
    localparam int FRAC_BITS_DEF = 24;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;

    localparam logic [CFG_IDX_W-1:0] REG_TEMP_COEFFS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_BASE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CROSS_COEFFS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SQUARE_COEFFS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CUBIC_COEFF   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_SCALE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_SCALE   = 3'd6;

    localparam logic [RAW_W-1:0] SCALE_RESET = 24'd524288;

    localparam logic signed [TEMP_W-1:0]  TEMP_MAX  = 24'sh7FFFFF;
    localparam logic signed [TEMP_W-1:0]  TEMP_MIN  = 24'sh800000;
    localparam logic signed [PRESS_W-1:0] PRESS_MAX = 32'sh7FFFFFFF;
    localparam logic signed [PRESS_W-1:0] PRESS_MIN = 32'sh80000000;

endpackage

FILE: design/bsc_div.sv
// Pipelined restoring divider: signed raw reading scaled by 2^FRAC_BITS over a factor.
`timescale 1ns / 1ps

module bsc_div
    import bsc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int WS        = 1
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic signed [RAW_W-1:0]        raw,
    input  logic [RAW_W-1:0]               factor,
    input  logic [WS-1:0]                  side_in,
    output logic                           out_valid,
    output logic signed [RAW_W+FRAC_BITS:0] q,
    output logic [WS-1:0]                  side_out
);

    localparam int MW = RAW_W + FRAC_BITS;

    logic [RAW_W-1:0] raw_u;
    logic [RAW_W-1:0] abs_in;
    logic [MW-1:0]    mag_in;
    logic [RAW_W-1:0] k_in;

    assign raw_u  = raw;
    assign abs_in = raw_u[RAW_W-1] ? (~raw_u + 1'b1) : raw_u;
    assign mag_in = {abs_in, {FRAC_BITS{1'b0}}};
    assign k_in   = (factor == '0) ? RAW_W'(1) : factor;

    logic [RAW_W-1:0] rem_reg  [MW];
    logic [MW-1:0]    num_reg  [MW];
    logic [RAW_W-1:0] k_reg    [MW];
    logic             neg_reg  [MW];
    logic [WS-1:0]    side_reg [MW];
    logic             vld_reg  [MW];

    for (genvar s = 0; s < MW; s++) begin : g_step
        logic [RAW_W-1:0] rem_src;
        logic [MW-1:0]    num_src;
        logic [RAW_W-1:0] k_src;
        logic             neg_src;
        logic [WS-1:0]    side_src;
        logic             vld_src;
        logic [RAW_W:0]   shifted;
        logic [RAW_W:0]   trial;
        logic             qbit;

        if (s == 0) begin : g_first
            assign rem_src  = '0;
            assign num_src  = mag_in;
            assign k_src    = k_in;
            assign neg_src  = raw_u[RAW_W-1];
            assign side_src = side_in;
            assign vld_src  = in_valid;
        end else begin : g_next
            assign rem_src  = rem_reg[s-1];
            assign num_src  = num_reg[s-1];
            assign k_src    = k_reg[s-1];
            assign neg_src  = neg_reg[s-1];
            assign side_src = side_reg[s-1];
            assign vld_src  = vld_reg[s-1];
        end

        assign shifted = {rem_src, num_src[MW-1]};
        assign trial   = shifted - {1'b0, k_src};
        assign qbit    = (shifted >= {1'b0, k_src});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (en) begin
                vld_reg[s] <= vld_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s]  <= qbit ? trial[RAW_W-1:0] : shifted[RAW_W-1:0];
                num_reg[s]  <= {num_src[MW-2:0], qbit};
                k_reg[s]    <= k_src;
                neg_reg[s]  <= neg_src;
                side_reg[s] <= side_src;
            end
        end
    end

    // round half away from zero: bump when the remainder is at least half the divisor
    logic          rnd;
    logic [MW-1:0] q_round;
    logic [MW:0]   q_zext;
    logic          out_valid_reg;
    logic signed [MW:0] q_reg;
    logic [WS-1:0] side_out_reg;

    assign rnd     = ({rem_reg[MW-1], 1'b0} >= {1'b0, k_reg[MW-1]});
    assign q_round = num_reg[MW-1] + MW'(rnd);
    assign q_zext  = {1'b0, q_round};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= vld_reg[MW-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg        <= neg_reg[MW-1] ? -$signed(q_zext) : $signed(q_zext);
            side_out_reg <= side_reg[MW-1];
        end
    end

    assign out_valid = out_valid_reg;
    assign q         = q_reg;
    assign side_out  = side_out_reg;

endmodule

FILE: design/bsc_mul.sv
// Pipelined signed multiplier, one 16-bit digit of b per stage, with a sideband carried along.
`timescale 1ns / 1ps

module bsc_mul
    import bsc_pkg::*;
#(
    parameter int WA = 32,
    parameter int WB = 16,
    parameter int WS = 1
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [WA-1:0]    a,
    input  logic signed [WB-1:0]    b,
    input  logic [WS-1:0]           side_in,
    output logic                    out_valid,
    output logic signed [WA+WB-1:0] p,
    output logic [WS-1:0]           side_out
);

    localparam int NS  = (WB + DIGIT_W - 1) / DIGIT_W;
    localparam int BXW = NS * DIGIT_W;
    localparam int PW  = WA + WB;

    logic signed [WA-1:0]  a_reg    [NS];
    logic signed [BXW-1:0] b_reg    [NS];
    logic signed [PW-1:0]  acc_reg  [NS];
    logic [WS-1:0]         side_reg [NS];
    logic                  vld_reg  [NS];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic signed [WA-1:0]        a_src;
        logic signed [BXW-1:0]       b_src;
        logic signed [PW-1:0]        acc_src;
        logic [WS-1:0]               side_src;
        logic                        vld_src;
        logic signed [DIGIT_W:0]     digit;
        logic signed [WA+DIGIT_W:0]  part;

        if (k == 0) begin : g_first
            assign a_src    = a;
            assign b_src    = BXW'(b);
            assign acc_src  = '0;
            assign side_src = side_in;
            assign vld_src  = in_valid;
        end else begin : g_next
            assign a_src    = a_reg[k-1];
            assign b_src    = b_reg[k-1];
            assign acc_src  = acc_reg[k-1];
            assign side_src = side_reg[k-1];
            assign vld_src  = vld_reg[k-1];
        end

        // top digit carries the sign, the rest are unsigned
        if (k == NS - 1) begin : g_top
            assign digit = {b_src[BXW-1], b_src[k*DIGIT_W +: DIGIT_W]};
        end else begin : g_low
            assign digit = {1'b0, b_src[k*DIGIT_W +: DIGIT_W]};
        end

        assign part = a_src * digit;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                a_reg[k]    <= a_src;
                b_reg[k]    <= b_src;
                acc_reg[k]  <= acc_src + (PW'(part) <<< (k * DIGIT_W));
                side_reg[k] <= side_src;
            end
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign p         = acc_reg[NS-1];
    assign side_out  = side_reg[NS-1];

endmodule

FILE: design/bsc_post.sv
// Final sums, round to output units and clip with a saturation flag.
`timescale 1ns / 1ps

module bsc_post
    import bsc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int TPW       = 61,
    parameter int CW        = 166,
    parameter int EW        = 164,
    parameter int GW        = 65
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic signed [11:0]        c0,
    input  logic signed [TPW-1:0]     tc1,
    input  logic signed [CW-1:0]      c_val,
    input  logic signed [EW-1:0]      e_val,
    input  logic signed [GW-1:0]      tc01,
    output logic                      out_valid,
    output logic signed [TEMP_W-1:0]  temperature,
    output logic signed [PRESS_W-1:0] pressure,
    output logic                      saturated
);

    localparam int TMW = TPW + 2;
    localparam int SW  = CW + 2;
    localparam int TSH = FRAC_BITS - 8;
    localparam int PSH = 3 * FRAC_BITS - 6;

    logic                  vld1_reg;
    logic signed [TMW-1:0] temp_reg;
    logic signed [SW-1:0]  sum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
        end else if (en) begin
            vld1_reg <= in_valid;
        end
    end

    // c0/2 kept exact: c0 at FRAC_BITS-1 fraction bits
    always_ff @(posedge aclk) begin
        if (en) begin
            temp_reg <= (TMW'(c0) <<< (FRAC_BITS - 1)) + TMW'(tc1);
            sum_reg  <= SW'(c_val) + SW'(e_val) + (SW'(tc01) <<< (2 * FRAC_BITS));
        end
    end

    logic signed [TMW-1:0]    temp_rnd;
    logic signed [SW-1:0]     sum_rnd;
    logic                     temp_ok;
    logic                     press_ok;
    logic signed [TEMP_W-1:0] temp_clip;
    logic signed [PRESS_W-1:0] press_clip;

    assign temp_rnd = (temp_reg + (TMW'(1) <<< (TSH - 1))) >>> TSH;
    assign sum_rnd  = (sum_reg + (SW'(1) <<< (PSH - 1))) >>> PSH;
    assign temp_ok  = (temp_rnd[TMW-1:TEMP_W-1] == '0) || (temp_rnd[TMW-1:TEMP_W-1] == '1);
    assign press_ok = (sum_rnd[SW-1:PRESS_W-1] == '0) || (sum_rnd[SW-1:PRESS_W-1] == '1);

    always_comb begin
        if (temp_ok) begin
            temp_clip = temp_rnd[TEMP_W-1:0];
        end else if (temp_rnd[TMW-1]) begin
            temp_clip = TEMP_MIN;
        end else begin
            temp_clip = TEMP_MAX;
        end
        if (press_ok) begin
            press_clip = sum_rnd[PRESS_W-1:0];
        end else if (sum_rnd[SW-1]) begin
            press_clip = PRESS_MIN;
        end else begin
            press_clip = PRESS_MAX;
        end
    end

    logic                      vld2_reg;
    logic signed [TEMP_W-1:0]  temperature_reg;
    logic signed [PRESS_W-1:0] pressure_reg;
    logic                      saturated_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld2_reg <= 1'b0;
        end else if (en) begin
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            temperature_reg <= temp_clip;
            pressure_reg    <= press_clip;
            saturated_reg   <= !(temp_ok && press_ok);
        end
    end

    assign out_valid   = vld2_reg;
    assign temperature = temperature_reg;
    assign pressure    = pressure_reg;
    assign saturated   = saturated_reg;

endmodule

FILE: design/bsc_skid.sv
// Output register with a skid slot; upstream pipeline advances whenever the slot is free.
`timescale 1ns / 1ps

module bsc_skid #(
    parameter int W = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);

    logic         out_valid_reg, out_valid_next;
    logic [W-1:0] out_data_reg, out_data_next;
    logic         skid_valid_reg, skid_valid_next;
    logic [W-1:0] skid_data_reg, skid_data_next;

    assign in_ready = !skid_valid_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (out_ready) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (in_valid) begin
            if (!out_valid_reg || out_ready) begin
                out_valid_next = 1'b1;
                out_data_next  = in_data;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = in_data;
            end
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: design/baro_sensor_compensation_core.sv
// Top level of the barometric temperature and pressure compensation core.
//
// Input stream: one raw temperature / pressure pair per transaction on s_*.
// Output stream: compensated temperature (1/256 degC), pressure (1/64 Pa) on
// m_tdata and a clip flag on m_tuser, one result per input transaction, in order.
// Coefficients and scale factors are written through cfg_we/cfg_index/cfg_wdata
// while no transaction is in flight.
// Throughput: one pair per clock while the output is not stalled. The pipeline
// is two restoring dividers, one quotient bit per stage, followed by a chain of
// digit-per-stage multipliers. The path from input transaction to output valid
// holds, at FRAC_BITS = 24, 2*(FRAC_BITS+25) divider stages, 30 multiplier digit
// stages (one per 16 bits of each multiplier's second operand), two rounding
// stages and the output register; the divider stages make up most of them.
// Reset clears all valid bits and loads the register defaults (scale factors
// 524288, coefficients zero). When the receiver stalls, a finished result waits
// in the output register, one more lands in the skid slot, and the pipeline
// then holds in place with s_tready low until the slot drains.
`timescale 1ns / 1ps

module baro_sensor_compensation_core
    import bsc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [47:0]           s_tdata,   // temp_sample[23:0], press_sample[47:24]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [55:0]           m_tdata,   // temperature[23:0], pressure[55:24]
    output logic [0:0]            m_tuser,   // saturated[0]
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int TW  = RAW_W + FRAC_BITS + 1;
    localparam int AW  = TW + 17;
    localparam int BW  = AW + TW + 1;
    localparam int CW  = BW + TW + 1;
    localparam int DW  = TW + 17;
    localparam int PDW = DW + TW;
    localparam int EW  = PDW + TW;
    localparam int OW  = TEMP_W + PRESS_W + 1;

    // configuration registers
    logic [23:0] temp_coeffs_reg;
    logic [39:0] press_base_reg;
    logic [31:0] cross_coeffs_reg;
    logic [31:0] square_coeffs_reg;
    logic [15:0] cubic_coeff_reg;
    logic [23:0] temp_scale_reg;
    logic [23:0] press_scale_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_coeffs_reg   <= '0;
            press_base_reg    <= '0;
            cross_coeffs_reg  <= '0;
            square_coeffs_reg <= '0;
            cubic_coeff_reg   <= '0;
            temp_scale_reg    <= SCALE_RESET;
            press_scale_reg   <= SCALE_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_TEMP_COEFFS:   temp_coeffs_reg   <= cfg_wdata[23:0];
                REG_PRESS_BASE:    press_base_reg    <= cfg_wdata[39:0];
                REG_CROSS_COEFFS:  cross_coeffs_reg  <= cfg_wdata[31:0];
                REG_SQUARE_COEFFS: square_coeffs_reg <= cfg_wdata[31:0];
                REG_CUBIC_COEFF:   cubic_coeff_reg   <= cfg_wdata[15:0];
                REG_TEMP_SCALE:    temp_scale_reg    <= cfg_wdata[23:0];
                REG_PRESS_SCALE:   press_scale_reg   <= cfg_wdata[23:0];
                default: ;
            endcase
        end
    end

    logic signed [11:0] c0, c1;
    logic signed [19:0] c00, c10;
    logic signed [15:0] c01, c11, c20, c21, c30;

    assign c0  = temp_coeffs_reg[23:12];
    assign c1  = temp_coeffs_reg[11:0];
    assign c00 = press_base_reg[39:20];
    assign c10 = press_base_reg[19:0];
    assign c01 = cross_coeffs_reg[31:16];
    assign c11 = cross_coeffs_reg[15:0];
    assign c20 = square_coeffs_reg[31:16];
    assign c21 = square_coeffs_reg[15:0];
    assign c30 = cubic_coeff_reg;

    logic en;
    assign s_tready = en;

    // scaling
    logic                 dt_valid;
    logic signed [TW-1:0] t_q;
    logic [RAW_W-1:0]     rawp_d;

    bsc_div #(.FRAC_BITS(FRAC_BITS), .WS(RAW_W)) u_div_t (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(s_tvalid), .raw(s_tdata[23:0]), .factor(temp_scale_reg),
        .side_in(s_tdata[47:24]),
        .out_valid(dt_valid), .q(t_q), .side_out(rawp_d)
    );

    logic                 dp_valid;
    logic signed [TW-1:0] p_q;
    logic [TW-1:0]        t_d;

    bsc_div #(.FRAC_BITS(FRAC_BITS), .WS(TW)) u_div_p (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(dt_valid), .raw(rawp_d), .factor(press_scale_reg),
        .side_in(t_q),
        .out_valid(dp_valid), .q(p_q), .side_out(t_d)
    );

    // a = c20*2^F + p*c30
    logic                    v1;
    logic signed [TW+15:0]   pc30;
    logic [2*TW-1:0]         s1;
    logic signed [AW-1:0]    a_val;

    bsc_mul #(.WA(TW), .WB(16), .WS(2*TW)) u_m1 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(dp_valid), .a(p_q), .b(c30), .side_in({t_d, p_q}),
        .out_valid(v1), .p(pc30), .side_out(s1)
    );
    assign a_val = (AW'(c20) <<< FRAC_BITS) + AW'(pc30);

    // b = c10*2^2F + p*a; the wide operand is cut into digits
    logic                    v2;
    logic signed [AW+TW-1:0] pa;
    logic [2*TW-1:0]         s2;
    logic signed [BW-1:0]    b_val;

    bsc_mul #(.WA(TW), .WB(AW), .WS(2*TW)) u_m2 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v1), .a(s1[TW-1:0]), .b(a_val), .side_in(s1),
        .out_valid(v2), .p(pa), .side_out(s2)
    );
    assign b_val = (BW'(c10) <<< (2 * FRAC_BITS)) + BW'(pa);

    // c = c00*2^3F + p*b
    logic                    v3;
    logic signed [BW+TW-1:0] pb;
    logic [2*TW-1:0]         s3;
    logic signed [CW-1:0]    c_val;

    bsc_mul #(.WA(TW), .WB(BW), .WS(2*TW)) u_m3 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v2), .a(s2[TW-1:0]), .b(b_val), .side_in(s2),
        .out_valid(v3), .p(pb), .side_out(s3)
    );
    assign c_val = (CW'(c00) <<< (3 * FRAC_BITS)) + CW'(pb);

    // d = c11*2^F + p*c21
    logic                    v4;
    logic signed [TW+15:0]   pc21;
    logic [2*TW+CW-1:0]      s4;
    logic signed [DW-1:0]    d_val;

    bsc_mul #(.WA(TW), .WB(16), .WS(2*TW+CW)) u_m4 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v3), .a(s3[TW-1:0]), .b(c21), .side_in({s3, c_val}),
        .out_valid(v4), .p(pc21), .side_out(s4)
    );
    assign d_val = (DW'(c11) <<< FRAC_BITS) + DW'(pc21);

    // side layout after m4: {t, p, c}
    logic                    v5;
    logic signed [PDW-1:0]   pd;
    logic [TW+CW-1:0]        s5;

    bsc_mul #(.WA(TW), .WB(DW), .WS(TW+CW)) u_m5 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v4), .a(s4[CW +: TW]), .b(d_val),
        .side_in({s4[CW+TW +: TW], s4[CW-1:0]}),
        .out_valid(v5), .p(pd), .side_out(s5)
    );

    // e = t*p*d, side {t, c}
    logic                    v6;
    logic signed [EW-1:0]    e_val;
    logic [TW+CW-1:0]        s6;

    bsc_mul #(.WA(TW), .WB(PDW), .WS(TW+CW)) u_m6 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v5), .a(s5[CW +: TW]), .b(pd), .side_in(s5),
        .out_valid(v6), .p(e_val), .side_out(s6)
    );

    // t*c01, side {t, c, e}
    logic                    v7;
    logic signed [TW+15:0]   tc01;
    logic [TW+CW+EW-1:0]     s7;

    bsc_mul #(.WA(TW), .WB(16), .WS(TW+CW+EW)) u_m7 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v6), .a(s6[CW +: TW]), .b(c01), .side_in({s6, e_val}),
        .out_valid(v7), .p(tc01), .side_out(s7)
    );

    // t*c1, side {c, e, t*c01}
    logic                    v8;
    logic signed [TW+11:0]   tc1;
    logic [CW+EW+TW+15:0]    s8;

    bsc_mul #(.WA(TW), .WB(12), .WS(CW+EW+TW+16)) u_m8 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v7), .a(s7[CW+EW +: TW]), .b(c1),
        .side_in({s7[CW+EW-1:0], tc01}),
        .out_valid(v8), .p(tc1), .side_out(s8)
    );

    logic                      post_valid;
    logic signed [TEMP_W-1:0]  temperature;
    logic signed [PRESS_W-1:0] pressure;
    logic                      saturated;

    bsc_post #(
        .FRAC_BITS(FRAC_BITS), .TPW(TW+12), .CW(CW), .EW(EW), .GW(TW+16)
    ) u_post (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v8), .c0(c0), .tc1(tc1),
        .c_val(s8[EW+TW+16 +: CW]), .e_val(s8[TW+16 +: EW]), .tc01(s8[TW+15:0]),
        .out_valid(post_valid),
        .temperature(temperature), .pressure(pressure), .saturated(saturated)
    );

    logic [OW-1:0] out_word;

    bsc_skid #(.W(OW)) u_skid (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(post_valid), .in_ready(en),
        .in_data({saturated, pressure, temperature}),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(out_word)
    );

    assign m_tdata = out_word[TEMP_W+PRESS_W-1:0];
    assign m_tuser = out_word[OW-1];

`ifndef SYNTHESIS
    // input only backs up while a result is held at the output
    a_stall_needs_output: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result held");

    a_ready_after_reset: assert property (@(posedge aclk)
        $past(!aresetn) |-> s_tready)
        else $error("not ready after reset");

    a_sat_at_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |->
            (m_tdata[23:0] == TEMP_MAX || m_tdata[23:0] == TEMP_MIN ||
             m_tdata[55:24] == PRESS_MAX || m_tdata[55:24] == PRESS_MIN))
        else $error("saturation flag without a clipped value");

    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (!s_tready && m_tready) |=> s_tready)
        else $error("skid slot failed to drain");
`endif

endmodule

FILE: sim/baro_sensor_compensation_core_test.sv
// Self-checking testbench for the barometric compensation core: random and directed stream traffic.
`timescale 1ns / 1ps

module baro_sensor_compensation_core_test;
    import bsc_pkg::*;

    typedef logic signed [255:0] wide_t;
    typedef struct {
        logic signed [23:0] temp;
        logic signed [31:0] press;
        logic               sat;
    } comp_t;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [47:0]           s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [55:0]           m_tdata;
    logic [0:0]            m_tuser;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // local copy of the register file
    logic [23:0] tc_reg, ts_reg, ps_reg;
    logic [39:0] pb_reg;
    logic [31:0] cr_reg, sq_reg;
    logic [15:0] c30_reg;

    logic [47:0] raw_pending[$];
    comp_t       comp_expect_q[$];
    int          errors = 0;
    int          cycles = 0;
    int          quiet = 0;
    int          hold_req = 0;
    int          hold_seen = 0;
    int          hold_cnt = 0;

    baro_sensor_compensation_core uut (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic logic signed [63:0] scale_reading(logic [23:0] raw, logic [23:0] fac);
        logic signed [63:0] r;
        logic [63:0]        k, mag, q;
        r = $signed(raw);
        k = (fac == 0) ? 64'd1 : 64'(fac);
        mag = 64'(r < 0 ? -r : r) << 24;
        q = (2 * mag + k) / (2 * k);
        return (r < 0) ? -$signed(q) : $signed(q);
    endfunction

    function automatic comp_t compensate(logic [47:0] raw);
        wide_t t, p, c0, c1, c00, c10, c01, c11, c20, c21, c30;
        wide_t tw, a, b, c, d, e, g, sum, rt, rp;
        comp_t res;
        t = scale_reading(raw[23:0], ts_reg);
        p = scale_reading(raw[47:24], ps_reg);
        c0 = $signed(tc_reg[23:12]);
        c1 = $signed(tc_reg[11:0]);
        c00 = $signed(pb_reg[39:20]);
        c10 = $signed(pb_reg[19:0]);
        c01 = $signed(cr_reg[31:16]);
        c11 = $signed(cr_reg[15:0]);
        c20 = $signed(sq_reg[31:16]);
        c21 = $signed(sq_reg[15:0]);
        c30 = $signed(c30_reg);
        res.sat = 1'b0;

        tw = (c0 <<< 23) + c1 * t;
        rt = (tw + (wide_t'(1) <<< 15)) >>> 16;
        if (rt > wide_t'(TEMP_MAX)) begin
            res.temp = TEMP_MAX;
            res.sat = 1'b1;
        end else if (rt < wide_t'(TEMP_MIN)) begin
            res.temp = TEMP_MIN;
            res.sat = 1'b1;
        end else begin
            res.temp = rt[23:0];
        end

        // pressure carries 72 fraction bits until the final rounding
        a = (c20 <<< 24) + p * c30;
        b = (c10 <<< 48) + p * a;
        c = (c00 <<< 72) + p * b;
        d = (c11 <<< 24) + p * c21;
        e = t * (p * d);
        g = (t * c01) <<< 48;
        sum = c + e + g;
        rp = (sum + (wide_t'(1) <<< 65)) >>> 66;
        if (rp > wide_t'(PRESS_MAX)) begin
            res.press = PRESS_MAX;
            res.sat = 1'b1;
        end else if (rp < wide_t'(PRESS_MIN)) begin
            res.press = PRESS_MIN;
            res.sat = 1'b1;
        end else begin
            res.press = rp[31:0];
        end
        return res;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
        end else begin
            if (s_tvalid && s_tready)
                comp_expect_q.push_back(compensate(s_tdata));
            if (!s_tvalid || s_tready) begin
                if (raw_pending.size() > 0 && (quiet || $urandom_range(99) >= 27)) begin
                    s_tdata <= raw_pending.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver ready, with the long hold-off counted here
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_cnt <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= quiet || $urandom_range(99) >= 27;
        end
    end

    // monitor
    always @(posedge aclk) begin
        comp_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (comp_expect_q.size() == 0) begin
                $error("result transaction with nothing expected: %h", m_tdata);
                errors++;
            end else begin
                want = comp_expect_q.pop_front();
                if ($signed(m_tdata[23:0]) != want.temp) begin
                    $error("temperature: expected %0d, got %0d", want.temp,
                           $signed(m_tdata[23:0]));
                    errors++;
                end
                if ($signed(m_tdata[55:24]) != want.press) begin
                    $error("pressure: expected %0d, got %0d", want.press,
                           $signed(m_tdata[55:24]));
                    errors++;
                end
                if (m_tuser[0] != want.sat) begin
                    $error("saturated: expected %0d, got %0d", want.sat, m_tuser[0]);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_TEMP_COEFFS:   tc_reg = val[23:0];
            REG_PRESS_BASE:    pb_reg = val[39:0];
            REG_CROSS_COEFFS:  cr_reg = val[31:0];
            REG_SQUARE_COEFFS: sq_reg = val[31:0];
            REG_CUBIC_COEFF:   c30_reg = val[15:0];
            REG_TEMP_SCALE:    ts_reg = val[23:0];
            REG_PRESS_SCALE:   ps_reg = val[23:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_coeffs(logic [23:0] tc, logic [39:0] pb, logic [31:0] cr,
                               logic [31:0] sq, logic [15:0] c30, logic [23:0] ts,
                               logic [23:0] ps);
        write_reg(REG_TEMP_COEFFS, 40'(tc));
        write_reg(REG_PRESS_BASE, pb);
        write_reg(REG_CROSS_COEFFS, 40'(cr));
        write_reg(REG_SQUARE_COEFFS, 40'(sq));
        write_reg(REG_CUBIC_COEFF, 40'(c30));
        write_reg(REG_TEMP_SCALE, 40'(ts));
        write_reg(REG_PRESS_SCALE, 40'(ps));
    endtask

    task automatic drain();
        while (raw_pending.size() > 0 || s_tvalid || comp_expect_q.size() > 0)
            @(posedge aclk);
        repeat (5) @(posedge aclk);
    endtask

    function automatic logic [23:0] rand_reading();
        case ($urandom_range(7))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($signed($urandom_range(64)) - 32);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] rand_factor();
        case ($urandom_range(5))
            0: return 24'($urandom_range(1));
            1: return 24'hFFFFFF;
            2: return 24'(1) << $urandom_range(23);
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic push_random(int n);
        repeat (n) raw_pending.push_back({rand_reading(), rand_reading()});
    endtask

    initial begin
        logic [23:0] corner[5] = '{24'h000000, 24'h000001, 24'hFFFFFF, 24'h7FFFFF, 24'h800000};
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        tc_reg = '0;
        pb_reg = '0;
        cr_reg = '0;
        sq_reg = '0;
        c30_reg = '0;
        ts_reg = SCALE_RESET;
        ps_reg = SCALE_RESET;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset defaults: all coefficients zero
        raw_pending.push_back({24'h7FFFFF, 24'h800000});
        raw_pending.push_back({24'h123456, 24'h0ABCDE});
        drain();

        // typical coefficient set, corner readings crossed
        load_coeffs({12'd408, 12'hEE0}, {20'd70000, 20'hB0000}, {16'hF8A0, 16'h0500},
                    {16'h3000, 16'h00A0}, 16'hFE20, 24'd524288, 24'd1572864);
        foreach (corner[i])
            foreach (corner[j])
                if (i < 4) raw_pending.push_back({corner[j], corner[i]});
        drain();

        // extreme coefficients with a zero and a unit scale factor
        load_coeffs(24'h7FF7FF, 40'h7FFFF7FFFF, 32'h7FFF7FFF, 32'h7FFF7FFF, 16'h7FFF,
                    24'd0, 24'd1);
        write_reg(3'd7, 40'hFFFFFFFFFF);
        foreach (corner[i]) raw_pending.push_back({corner[i], corner[4 - i]});
        drain();
        load_coeffs(24'h800800, 40'h8000080000, 32'h80008000, 32'h80008000, 16'h8000,
                    24'hFFFFFF, 24'hFFFFFF);
        foreach (corner[i]) raw_pending.push_back({corner[i], corner[i]});
        drain();

        // random phases; one runs without idling and with a long receiver hold,
        // long enough to fill the whole pipeline and stall the input
        for (int ph = 0; ph < 7; ph++) begin
            load_coeffs(24'($urandom), {8'($urandom), 32'($urandom)}, $urandom, $urandom,
                        16'($urandom), rand_factor(), rand_factor());
            quiet = (ph == 3);
            push_random((ph == 3) ? 220 : 80);
            if (ph == 2 || ph == 3) begin
                while (comp_expect_q.size() == 0) @(posedge aclk);
                hold_req <= hold_req + 1;
            end
            drain();
        end
        quiet = 0;
        load_coeffs(24'd0, 40'd0, 32'd0, 32'd0, 16'd0, SCALE_RESET, SCALE_RESET);
        push_random(10);
        drain();

        repeat (200) @(posedge aclk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: filelist.f
design/bsc_pkg.sv
design/bsc_div.sv
design/bsc_mul.sv
design/bsc_post.sv
design/bsc_skid.sv
design/baro_sensor_compensation_core.sv
sim/baro_sensor_compensation_core_test.sv
